@@ rtl/pmct_pkg.sv @@
package pmct_pkg;

    // Packet phase codes
    localparam logic [1:0] PHASE_FLAGS = 2'd0;
    localparam logic [1:0] PHASE_DX    = 2'd1;
    localparam logic [1:0] PHASE_DY    = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_MAX_COLUMN = 2'd0;
    localparam logic [1:0] REG_MAX_ROW    = 2'd1;

    // Reset values of the limits
    localparam logic [7:0] MAX_COLUMN_RESET = 8'd79;
    localparam logic [7:0] MAX_ROW_RESET    = 8'd24;

    // Flags byte layout
    localparam logic [7:0] ACK_BYTE        = 8'hFA;
    localparam int         BIT_ALWAYS_ONE  = 3;
    localparam int         BIT_X_SIGN      = 4;
    localparam int         BIT_Y_SIGN      = 5;
    localparam int         BIT_X_OVF       = 6;
    localparam int         BIT_Y_OVF       = 7;

    // Halve a 9-bit signed delta, truncating toward zero.
    function automatic logic signed [7:0] half_delta(input logic [7:0] b, input logic neg);
        logic signed [8:0] v;
        logic signed [8:0] r;
        begin
            v = $signed({neg, b});
            r = (v + $signed({8'd0, neg})) >>> 1;
            half_delta = r[7:0];
        end
    endfunction

    // Clamp to zero first, then to the maximum.
    function automatic logic [7:0] clamp_pos(input logic signed [9:0] v, input logic [7:0] hi);
        logic signed [9:0] t;
        begin
            t = (v <= 10'sd0) ? 10'sd0 : v;
            if (t >= $signed({2'b00, hi}))
            begin
                t = $signed({2'b00, hi});
            end
            clamp_pos = t[7:0];
        end
    endfunction

endpackage

@@ rtl/ps2_mouse_packet_cursor_tracker_unit.sv @@
// Channel   Direction  Payload
// s_axis    in         tdata[7:0]  = rx_byte
// m_axis    out        tdata[7:0]  = cursor_column, tdata[15:8] = cursor_row
// cfg       in         index 0 = max_column, index 1 = max_row
//
// Each accepted byte is handled in the cycle it is taken; one byte per cycle while s_tready is high.
// A packet's result appears in the output register the cycle after its dy beat.
// s_tready stays high while the output register is empty or being drained,
// so only a held result with m_tready low stalls the input.
// Reset clears the phase, the sign bits, the position and restores the limits.
module ps2_mouse_packet_cursor_tracker_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] cursor_column, [15:8] cursor_row
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  sign_reg, sign_next;
    logic [7:0]  held_dx_reg, held_dx_next;
    logic [7:0]  column_reg, column_next;
    logic [7:0]  row_reg, row_next;
    logic [7:0]  max_column_reg;
    logic [7:0]  max_row_reg;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_data_reg, out_data_next;
    logic        accept;
    logic        emit;
    logic signed [7:0] hx;
    logic signed [7:0] hy;
    logic flags_ok;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign hx = pmct_pkg::half_delta(held_dx_reg, sign_reg[0]);
    assign hy = pmct_pkg::half_delta(s_tdata, sign_reg[1]);

    // Every flags byte is consumed, but it starts a packet only when it passes all framing checks.
    assign flags_ok = (s_tdata != 8'd0) && (s_tdata != pmct_pkg::ACK_BYTE)
                   && s_tdata[pmct_pkg::BIT_ALWAYS_ONE]
                   && !s_tdata[pmct_pkg::BIT_X_OVF]
                   && !s_tdata[pmct_pkg::BIT_Y_OVF];

    // Packet phase machine and position update.
    always_comb
    begin
        phase_next   = phase_reg;
        sign_next    = sign_reg;
        held_dx_next = held_dx_reg;
        column_next  = column_reg;
        row_next     = row_reg;
        emit         = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                pmct_pkg::PHASE_DX:
                begin
                    held_dx_next = s_tdata;
                    phase_next   = pmct_pkg::PHASE_DY;
                end
                pmct_pkg::PHASE_DY:
                begin
                    column_next = pmct_pkg::clamp_pos(
                        $signed({2'b00, column_reg}) + 10'(hx), max_column_reg);
                    row_next    = pmct_pkg::clamp_pos(
                        $signed({2'b00, row_reg}) - 10'(hy), max_row_reg);
                    phase_next  = pmct_pkg::PHASE_FLAGS;
                    emit        = 1'b1;
                end
                default:
                begin
                    // Idle phase; the unused code behaves the same way.
                    phase_next = pmct_pkg::PHASE_FLAGS;
                    if (flags_ok)
                    begin
                        sign_next  = {s_tdata[pmct_pkg::BIT_Y_SIGN],
                                      s_tdata[pmct_pkg::BIT_X_SIGN]};
                        phase_next = pmct_pkg::PHASE_DX;
                    end
                end
            endcase
        end
    end

    // Output register: loads a new result, or empties when the beat is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {row_next, column_next};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and position state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= pmct_pkg::PHASE_FLAGS;
            sign_reg       <= 2'd0;
            held_dx_reg    <= 8'd0;
            column_reg     <= 8'd0;
            row_reg        <= 8'd0;
            out_valid_reg  <= 1'b0;
            max_column_reg <= pmct_pkg::MAX_COLUMN_RESET;
            max_row_reg    <= pmct_pkg::MAX_ROW_RESET;
        end
        else
        begin
            phase_reg     <= phase_next;
            sign_reg      <= sign_next;
            held_dx_reg   <= held_dx_next;
            column_reg    <= column_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && (cfg_index == pmct_pkg::REG_MAX_COLUMN))
            begin
                max_column_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == pmct_pkg::REG_MAX_ROW))
            begin
                max_row_reg <= cfg_data;
            end
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

@@ test/ps2_mouse_packet_cursor_tracker_unit_tb.sv @@
`timescale 1ns / 100ps

module ps2_mouse_packet_cursor_tracker_unit_tb;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 3;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_BYTES   = 310;

    // Indexes past the two limit registers; writes there must have no effect.
    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;

    typedef struct {
        logic [7:0] column;
        logic [7:0] row;
    } cursor_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;      // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;             // [7:0] cursor_column, [15:8] cursor_row
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [7:0]  cfg_data = 8'd0;

    // Model of the tracker: limits, packet phase, held bytes and position.
    logic [7:0] lim_column = pmct_pkg::MAX_COLUMN_RESET;
    logic [7:0] lim_row    = pmct_pkg::MAX_ROW_RESET;
    logic [1:0] pkt_phase  = pmct_pkg::PHASE_FLAGS;
    logic       x_neg      = 1'b0;
    logic       y_neg      = 1'b0;
    logic [7:0] dx_hold    = 8'd0;
    logic [7:0] col_now    = 8'd0;
    logic [7:0] row_now    = 8'd0;

    cursor_t cursor_expected[$];

    int errors = 0;
    int cycles = 0;
    int bytes_sent = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;

    ps2_mouse_packet_cursor_tracker_unit u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // Run limit in case the block hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Zero first, then the upper limit, so a limit of zero pins the position.
    function automatic logic [7:0] clip_to(input int v, input logic [7:0] lim);
        if (v <= 0)
            v = 0;
        if (v >= int'(lim))
            v = int'(lim);
        return v[7:0];
    endfunction

    // Advance the model by one received byte; a finished packet queues a position.
    task automatic track_cursor(input logic [7:0] b);
        int hx;
        int hy;
        cursor_t c;
        case (pkt_phase)
            pmct_pkg::PHASE_DX:
            begin
                dx_hold = b;
                pkt_phase = pmct_pkg::PHASE_DY;
            end
            pmct_pkg::PHASE_DY:
            begin
                // Nine-bit deltas halved with truncation toward zero.
                hx = int'(dx_hold);
                if (x_neg)
                    hx = hx - 256;
                hx = hx / 2;
                hy = int'(b);
                if (y_neg)
                    hy = hy - 256;
                hy = hy / 2;
                col_now = clip_to(int'(col_now) + hx, lim_column);
                row_now = clip_to(int'(row_now) - hy, lim_row);
                pkt_phase = pmct_pkg::PHASE_FLAGS;
                c.column = col_now;
                c.row = row_now;
                cursor_expected.push_back(c);
            end
            default:
            begin
                pkt_phase = pmct_pkg::PHASE_FLAGS;
                if (b != 8'd0 && b != pmct_pkg::ACK_BYTE &&
                    b[pmct_pkg::BIT_ALWAYS_ONE] &&
                    !b[pmct_pkg::BIT_X_OVF] && !b[pmct_pkg::BIT_Y_OVF])
                begin
                    x_neg = b[pmct_pkg::BIT_X_SIGN];
                    y_neg = b[pmct_pkg::BIT_Y_SIGN];
                    pkt_phase = pmct_pkg::PHASE_DX;
                end
            end
        endcase
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Compare every output beat with the oldest queued position.
    always @(posedge clk)
    begin
        cursor_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (cursor_expected.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got column %0d row %0d",
                         $time, m_tdata[7:0], m_tdata[15:8]);
                errors++;
            end
            else
            begin
                want = cursor_expected.pop_front();
                if (m_tdata[7:0] !== want.column)
                begin
                    $display("%0t: cursor_column mismatch, expected %0d, got %0d",
                             $time, want.column, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[15:8] !== want.row)
                begin
                    $display("%0t: cursor_row mismatch, expected %0d, got %0d",
                             $time, want.row, m_tdata[15:8]);
                    errors++;
                end
            end
        end
    end

    // Offer one byte after a random gap and wait for the beat to be taken.
    // Valid stays high afterward so back-to-back bytes need no second assignment.
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        track_cursor(b);
        bytes_sent++;
    endtask

    task automatic send_packet(input logic [7:0] flags, input logic [7:0] dx,
                               input logic [7:0] dy);
        send_byte(flags);
        send_byte(dx);
        send_byte(dy);
    endtask

    // Drop valid, let every queued position arrive, then let the block settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (cursor_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_reg(input logic [1:0] idx, input logic [7:0] val);
        if (idx == pmct_pkg::REG_MAX_COLUMN)
            lim_column = val;
        else if (idx == pmct_pkg::REG_MAX_ROW)
            lim_row = val;
    endtask

    // Two register writes on consecutive cycles while the block is idle.
    task automatic configure(input logic [1:0] ia, input logic [7:0] va,
                             input logic [1:0] ib, input logic [7:0] vb);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= ia;
        cfg_data <= va;
        @(posedge clk);
        apply_reg(ia, va);
        cfg_index <= ib;
        cfg_data <= vb;
        @(posedge clk);
        apply_reg(ib, vb);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_delta();
        case ($urandom_range(19))
            0: return 8'h00;
            1: return pmct_pkg::ACK_BYTE;
            2: return 8'h80;
            3: return 8'h7F;
            4: return 8'hFF;
            5: return 8'h01;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Valid flags byte: overflow clear, always-one set, random signs and buttons.
    function automatic logic [7:0] pick_flags();
        return {2'b00, 2'($urandom_range(3)), 1'b1, 3'($urandom_range(7))};
    endfunction

    function automatic logic [7:0] pick_limit();
        case ($urandom_range(9))
            0: return 8'd1;
            1: return 8'd255;
            default: return 8'($urandom_range(255, 1));
        endcase
    endfunction

    // Rejected flags bytes, then packets hitting the sign, halving and clamp corners.
    task automatic test_directed_packets();
        send_byte(8'h00);
        send_byte(pmct_pkg::ACK_BYTE);
        send_byte(8'h07);
        send_byte(8'h48);
        send_byte(8'h88);
        send_packet(8'h08, pmct_pkg::ACK_BYTE, 8'h00);
        send_packet(8'h38, 8'h80, 8'hFF);
        send_packet(8'h28, 8'h00, 8'h80);
        send_packet(8'h18, 8'hFF, 8'h7F);
        send_packet(8'h0F, 8'h03, 8'hFE);
        send_packet(8'h3F, 8'h01, 8'h01);
    endtask

    // Widest and narrowest limits, a lowered limit, and writes to unused indexes.
    task automatic test_limit_extremes();
        configure(pmct_pkg::REG_MAX_COLUMN, 8'd255, pmct_pkg::REG_MAX_ROW, 8'd255);
        send_packet(8'h08, 8'hFE, 8'h00);
        send_packet(8'h08, 8'hFE, 8'h00);
        send_packet(8'h28, 8'h7F, 8'h00);
        send_packet(8'h28, 8'h00, 8'h02);
        send_packet(8'h28, 8'h00, 8'h00);
        configure(pmct_pkg::REG_MAX_COLUMN, 8'd10, pmct_pkg::REG_MAX_ROW, 8'd5);
        send_packet(8'h08, 8'h00, 8'h00);
        configure(pmct_pkg::REG_MAX_COLUMN, 8'd0, pmct_pkg::REG_MAX_ROW, 8'd0);
        send_packet(8'h28, 8'h7F, 8'h80);
        configure(REG_SPARE_A, 8'h33, REG_SPARE_B, 8'h44);
        send_packet(8'h28, 8'h7F, 8'h80);
        configure(pmct_pkg::REG_MAX_COLUMN, 8'd1, pmct_pkg::REG_MAX_ROW, 8'd1);
        send_packet(8'h28, 8'h7F, 8'h80);
        send_packet(8'h18, 8'h80, 8'h7F);
        configure(pmct_pkg::REG_MAX_COLUMN, pmct_pkg::MAX_COLUMN_RESET,
                  pmct_pkg::REG_MAX_ROW, pmct_pkg::MAX_ROW_RESET);
    endtask

    // Receiver holds off while packets keep coming, so the input must stall.
    task automatic test_backpressure();
        wait_idle();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_token++;
        repeat (12) send_packet(pick_flags(), pick_delta(), pick_delta());
    endtask

    // Mostly well-formed packets with random content, the rest random noise.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        int stop_at;
        configure(pmct_pkg::REG_MAX_COLUMN, pick_limit(), pmct_pkg::REG_MAX_ROW, pick_limit());
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        stop_at = bytes_sent + PHASE_BYTES;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(99) < 85)
                send_packet(pick_flags(), pick_delta(), pick_delta());
            else
                send_byte(8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_packets();
        test_limit_extremes();
        test_backpressure();
        test_random_traffic(0, 0);
        test_random_traffic(71, 0);
        test_random_traffic(0, 71);
        test_random_traffic(35, 35);

        wait_idle();
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/pmct_pkg.sv
rtl/ps2_mouse_packet_cursor_tracker_unit.sv
test/ps2_mouse_packet_cursor_tracker_unit_tb.sv
